// ===== hw/rtl/lcdfb_pkg.sv =====
package lcdfb_pkg;

  localparam int unsigned ColsW     = 7;
  localparam int unsigned FrameW    = 9;
  localparam int unsigned FontDepth = 4096;
  localparam int unsigned FontAw    = 12;

  typedef enum logic [2:0] {
    REQ_FONT   = 3'd0,
    REQ_LOCATE = 3'd1,
    REQ_PUTC   = 3'd2,
    REQ_PIXEL  = 3'd3,
    REQ_CLEAR  = 3'd4,
    REQ_REFR   = 3'd5
  } req_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HDR,
    ST_HDRW,
    ST_WRAP,
    ST_BASE,
    ST_FADDR,
    ST_FWAIT,
    ST_PRD,
    ST_PWR,
    ST_ADV,
    ST_ADVX,
    ST_ADVW,
    ST_CLR,
    ST_RRD,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [2:0] req_type;
    logic [11:0] font_addr;
    logic [7:0] font_byte;
    logic [7:0] char_code;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic pixel_on;
  } req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic out_is_data;
    logic out_valid;
    logic frame_done;
    logic [7:0] cur_x;
    logic [7:0] cur_y;
  } rsp_t;

  localparam logic [7:0] CmdColLo   = 8'h00;
  localparam logic [7:0] CmdColHi   = 8'h10;
  localparam logic [7:0] CmdPage    = 8'hB0;
  localparam logic [7:0] NlCode     = 8'd10;
  localparam logic [7:0] GlyphFirst = 8'd32;
  localparam logic [7:0] GlyphLast  = 8'd127;

endpackage

// ===== hw/rtl/lcd_text_framebuffer_engine_unit.sv =====
// Page-mode LCD text framebuffer engine.
// Command channel: a request transfers on a clock edge with start high and
// busy low; busy stays high until the single result is shown. The result
// stays on rsp_o until the next; done_o marks it for exactly one cycle;
// the receiver cannot hold it off, so nothing ever stalls on the result side.
// Config channel: cfg_valid_i/cfg_ready_o write the 2-bit orientation; taken
// whenever the engine is idle.
// Work from transfer to result: font write, locate, ignored codes and
// unused request codes: none. Pixel: one frame memory read-modify-write.
// Refresh pull: one frame memory read. Clear: one byte per cycle. Newline:
// reads the glyph header. Character: header, then width * height pixels;
// one font memory read and one frame memory read-modify-write per pixel.
// A new request can transfer in the cycle its predecessor's result is shown.
// Reset clears cursor, refresh position, orientation and starts a clear sweep
// of the 512 frame memory bytes during which busy is high; the sweep gives
// no result. Font memory is not cleared and must be loaded before use.
module lcd_text_framebuffer_engine_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  lcdfb_pkg::req_t req_i,
  output logic            done_o,
  output lcdfb_pkg::rsp_t rsp_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [1:0]      cfg_data_i
);
  import lcdfb_pkg::*;

  localparam int unsigned FaW = FontAw;
  localparam int unsigned FrameBytes = 512;
  localparam int unsigned FrameSlots = 524;
  localparam int unsigned PageSlots = 131;

  logic [7:0] font_mem [FontDepth];
  logic [7:0] frame_mem [FrameBytes];

  state_e state_q, state_d;
  req_t req_q;
  logic boot_q;
  logic [1:0] orient_q;
  logic [7:0] cx_q, cy_q;
  logic [9:0] rpos_q;
  logic [1:0] rpage_q;
  logic [7:0] rk_q;
  logic [FrameW-1:0] clr_q;
  logic [1:0] hidx_q;
  logic [7:0] per_q, hor_q, vert_q, bpl_q;
  logic [FaW-1:0] base_q, fa_q;
  logic [7:0] fd_q, frd_q;
  logic [7:0] i_q, j_q, x0_q, y0_q;
  logic [FrameW-1:0] pidx_q;
  logic [2:0] pbit_q;
  logic pon_q, pvalid_q, pix_req_q;
  rsp_t rsp_q, rsp_d;
  logic done_q;

  // font memory
  logic f_we;
  logic [FaW-1:0] f_wa, f_ra;
  always_ff @(posedge clk_i) begin
    if (f_we) font_mem[f_wa] <= req_q.font_byte;
    fd_q <= font_mem[f_ra];
  end

  // frame memory
  logic m_we;
  logic [FrameW-1:0] m_wa, m_ra;
  logic [7:0] m_wd;
  always_ff @(posedge clk_i) begin
    if (m_we) frame_mem[m_wa] <= m_wd;
    frd_q <= frame_mem[m_ra];
  end

  assign busy = (state_q != ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign done_o = done_q;
  assign rsp_o = rsp_q;

  // newline helper
  logic [7:0] nl_y;
  logic [9:0] th;
  always_comb begin
    nl_y = cy_q + vert_q;
    th = orient_q[0] ? 10'd32 : 10'd128;
    if ($signed({2'b00, nl_y}) >= $signed(th - {2'b00, vert_q})) nl_y = '0;
  end

  logic [9:0] xsum;
  assign xsum = {2'b00, cx_q} + {2'b00, hor_q};
  // glyph pixel coordinates wrap at 8 bits
  logic [7:0] px, py;
  assign px = x0_q + i_q;
  assign py = y0_q + j_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (start) begin
        case (req_i.req_type)
          REQ_PUTC:  state_d = (req_i.char_code == NlCode ||
                                (req_i.char_code >= GlyphFirst &&
                                 req_i.char_code <= GlyphLast)) ? ST_HDR : ST_DONE;
          REQ_PIXEL: state_d = ST_PRD;
          REQ_CLEAR: state_d = ST_CLR;
          REQ_REFR:  state_d = ST_RRD;
          default:   state_d = ST_DONE;
        endcase
      end
      ST_HDR:  state_d = ST_HDRW;
      ST_HDRW: state_d = (hidx_q == 2'd3) ? ST_WRAP : ST_HDR;
      ST_WRAP: state_d = (req_q.char_code == NlCode) ? ST_DONE : ST_BASE;
      ST_BASE: state_d = (vert_q == 0 || hor_q == 0) ? ST_ADVX : ST_FADDR;
      ST_FADDR: state_d = ST_FWAIT;
      ST_FWAIT: state_d = ST_PRD;
      ST_PRD:  state_d = ST_PWR;
      ST_PWR:  state_d = pix_req_q ? ST_DONE : ST_ADV;
      ST_ADV:  state_d = (i_q + 8'd1 == hor_q && j_q + 8'd1 == vert_q) ? ST_ADVX : ST_FADDR;
      ST_ADVX: state_d = ST_ADVW;
      ST_ADVW: state_d = ST_DONE;
      ST_CLR: begin
        if (clr_q == FrameW'(FrameBytes - 1)) state_d = boot_q ? ST_IDLE : ST_DONE;
      end
      ST_RRD:  state_d = ST_DONE;
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    f_we = 1'b0;
    f_wa = FaW'(req_q.font_addr);
    f_ra = fa_q;
    m_we = 1'b0;
    m_wa = pidx_q;
    m_ra = pidx_q;
    m_wd = pon_q ? (frd_q | (8'd1 << pbit_q)) : (frd_q & ~(8'd1 << pbit_q));
    case (state_q)
      ST_DONE: f_we = (req_q.req_type == REQ_FONT);
      ST_HDR:  f_ra = FaW'(hidx_q);
      ST_ADVX: f_ra = base_q;
      ST_PWR:  m_we = pvalid_q;
      ST_CLR:  begin m_we = 1'b1; m_wa = clr_q; m_wd = '0; end
      ST_RRD:  m_ra = {rpage_q, rk_q[ColsW-1:0] - 7'd3};
      default: ;
    endcase
  end

  always_comb begin
    rsp_d = '0;
    rsp_d.cur_x = cx_q;
    rsp_d.cur_y = cy_q;
    if (req_q.req_type == REQ_REFR) begin
      rsp_d.out_valid = 1'b1;
      case (rk_q)
        8'd0: rsp_d.out_byte = CmdColLo;
        8'd1: rsp_d.out_byte = CmdColHi;
        8'd2: rsp_d.out_byte = CmdPage | {6'd0, rpage_q};
        default: begin rsp_d.out_byte = frd_q; rsp_d.out_is_data = 1'b1; end
      endcase
      rsp_d.frame_done = (rpos_q == 10'(FrameSlots - 1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      boot_q <= 1'b1;
      req_q <= '0;
      orient_q <= '0; cx_q <= '0; cy_q <= '0;
      rpos_q <= '0; rpage_q <= '0; rk_q <= '0;
      clr_q <= '0; done_q <= 1'b0; hidx_q <= '0;
      per_q <= '0; hor_q <= '0; vert_q <= '0; bpl_q <= '0;
      base_q <= '0; fa_q <= '0;
      i_q <= '0; j_q <= '0; x0_q <= '0; y0_q <= '0;
      pidx_q <= '0; pbit_q <= '0; pon_q <= 1'b0; pvalid_q <= 1'b0;
      pix_req_q <= 1'b0; rsp_q <= '0;
    end else begin
      state_q <= state_d;
      done_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) orient_q <= cfg_data_i;
      case (state_q)
        ST_IDLE: if (start) begin
          req_q <= req_i;
          hidx_q <= '0;
          clr_q <= '0;
          pix_req_q <= (req_i.req_type == REQ_PIXEL);
          if (req_i.req_type == REQ_LOCATE) begin
            cx_q <= req_i.pos_x; cy_q <= req_i.pos_y;
          end
          if (req_i.req_type == REQ_PIXEL) begin
            pvalid_q <= !req_i.pos_x[7] && req_i.pos_y < 8'd32;
            pidx_q <= {req_i.pos_y[4:3], req_i.pos_x[6:0]};
            pbit_q <= req_i.pos_y[2:0];
            pon_q <= req_i.pixel_on;
          end
        end
        ST_HDR: ;
        ST_HDRW: begin
          case (hidx_q)
            2'd0: per_q <= fd_q;
            2'd1: hor_q <= fd_q;
            2'd2: vert_q <= fd_q;
            default: bpl_q <= fd_q;
          endcase
          hidx_q <= hidx_q + 2'd1;
        end
        ST_WRAP: begin
          if (req_q.char_code == NlCode ||
              xsum > (orient_q[0] ? 10'd128 : 10'd32)) begin
            cx_q <= '0; cy_q <= nl_y;
            x0_q <= '0; y0_q <= nl_y;
          end else begin
            x0_q <= cx_q; y0_q <= cy_q;
          end
          base_q <= FaW'(32'((req_q.char_code - 8'd32)) * 32'(per_q) + 32'd4);
          i_q <= '0; j_q <= '0;
        end
        ST_BASE: ;
        ST_FADDR: fa_q <= base_q + FaW'(32'(bpl_q) * 32'(i_q)) + FaW'(j_q[7:3]) + FaW'(1);
        // frame address is set here so the read in ST_PRD sees it
        ST_FWAIT: begin
          pvalid_q <= !px[7] && (py[7:5] == 3'd0);
          pidx_q <= {py[4:3], px[6:0]};
          pbit_q <= py[2:0];
        end
        ST_PRD: if (!pix_req_q) pon_q <= fd_q[j_q[2:0]];
        ST_PWR: ;
        ST_ADV: begin
          if (i_q + 8'd1 == hor_q) begin i_q <= '0; j_q <= j_q + 8'd1; end
          else i_q <= i_q + 8'd1;
        end
        ST_ADVX: ;
        // glyph width byte read in ST_ADVX
        ST_ADVW: cx_q <= cx_q + fd_q;
        ST_CLR: begin
          clr_q <= clr_q + FrameW'(1);
          if (clr_q == FrameW'(FrameBytes - 1)) boot_q <= 1'b0;
        end
        ST_RRD: ;
        ST_DONE: begin
          done_q <= 1'b1;
          rsp_q <= rsp_d;
          if (req_q.req_type == REQ_REFR) begin
            if (rpos_q == 10'(FrameSlots - 1)) begin
              rpos_q <= '0; rpage_q <= '0; rk_q <= '0;
            end else begin
              rpos_q <= rpos_q + 10'd1;
              if (rk_q == 8'(PageSlots - 1)) begin
                rk_q <= '0; rpage_q <= rpage_q + 2'd1;
              end else rk_q <= rk_q + 8'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> $past(busy));
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("double result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.out_is_data |-> rsp_o.out_valid) else $error("data without valid");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import lcdfb_pkg::*;

  localparam int unsigned FontBytes = 4096;
  localparam int unsigned FontLoad = 512;
  localparam int unsigned PageSlots = 131;
  localparam int unsigned FrameSlots = 4 * PageSlots;
  localparam logic [2:0] ReqSpare6 = 3'd6;
  localparam logic [2:0] ReqSpare7 = 3'd7;
  localparam logic [7:0] CodeFirstGlyph = 8'd32;
  localparam logic [7:0] CodeLastGlyph = 8'd127;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req = '0;
  logic done;
  rsp_t rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_data = '0;

  lcd_text_framebuffer_engine_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start      (start),
    .busy       (busy),
    .req_i      (req),
    .done_o     (done),
    .rsp_o      (rsp),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow of the engine state
  logic [7:0] font_mem [FontBytes];
  logic [7:0] frame_mem [512];
  logic [7:0] cur_x_q, cur_y_q;
  int unsigned refresh_slot;
  logic [1:0] orient_q;

  rsp_t pending_rsp [$];
  int unsigned fail_cnt = 0;
  bit calm = 0;

  function automatic void line_feed();
    int h;
    h = font_mem[2];
    cur_x_q = '0;
    cur_y_q = cur_y_q + 8'(h);
    if (int'(cur_y_q) >= ((orient_q[0]) ? 32 : 128) - h) cur_y_q = '0;
  endfunction

  function automatic void plot(int x, int y, bit on);
    int idx;
    if (x >= 128 || y >= 32) return;
    idx = x + (y >> 3) * 128;
    frame_mem[idx][y & 7] = on;
  endfunction

  function automatic void render_glyph(int c);
    int per, hor, vert, bpl, base;
    int x0, y0;
    logic [7:0] col;
    if (c < CodeFirstGlyph || c > CodeLastGlyph) return;
    per = font_mem[0];
    hor = font_mem[1];
    vert = font_mem[2];
    bpl = font_mem[3];
    if (int'(cur_x_q) + hor > ((orient_q[0]) ? 128 : 32)) line_feed();
    x0 = cur_x_q;
    y0 = cur_y_q;
    base = (c - 32) * per + 4;
    for (int j = 0; j < vert; j++) begin
      for (int i = 0; i < hor; i++) begin
        col = font_mem[(base + bpl * i + (j >> 3) + 1) % FontBytes];
        plot((x0 + i) & 255, (y0 + j) & 255, col[j & 7]);
      end
    end
    cur_x_q = cur_x_q + font_mem[base % FontBytes];
  endfunction

  function automatic rsp_t engine_result(req_t r);
    rsp_t e;
    int unsigned pg, k;
    e = '0;
    case (r.req_type)
      REQ_FONT:   font_mem[r.font_addr] = r.font_byte;
      REQ_LOCATE: begin
        cur_x_q = r.pos_x;
        cur_y_q = r.pos_y;
      end
      REQ_PUTC: begin
        if (r.char_code == NlCode) line_feed();
        else render_glyph(r.char_code);
      end
      REQ_PIXEL:  plot(r.pos_x, r.pos_y, r.pixel_on);
      REQ_CLEAR:  foreach (frame_mem[i]) frame_mem[i] = '0;
      REQ_REFR: begin
        pg = refresh_slot / PageSlots;
        k = refresh_slot % PageSlots;
        e.out_valid = 1'b1;
        if (k == 0) e.out_byte = CmdColLo;
        else if (k == 1) e.out_byte = CmdColHi;
        else if (k == 2) e.out_byte = CmdPage | 8'(pg);
        else begin
          e.out_is_data = 1'b1;
          e.out_byte = frame_mem[pg * 128 + k - 3];
        end
        if (refresh_slot == FrameSlots - 1) begin
          e.frame_done = 1'b1;
          refresh_slot = 0;
        end else refresh_slot++;
      end
      default: ;
    endcase
    e.cur_x = cur_x_q;
    e.cur_y = cur_y_q;
    return e;
  endfunction

  // leaves start high after the transfer; the next call lowers or keeps it
  task automatic send_req(req_t r);
    if (!calm && $urandom_range(99) < 35) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    req <= r;
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
    pending_rsp.push_back(engine_result(r));
  endtask

  task automatic idle_out();
    start <= 1'b0;
    @(posedge clk);
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  task automatic write_orient(logic [1:0] v);
    idle_out();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    forever begin
      @(negedge clk);
      if (cfg_ready) break;
    end
    @(posedge clk);
    orient_q = v;
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    rsp_t e;
    if (done) begin
      if (pending_rsp.size() == 0) begin
        $error("result with nothing expected");
        fail_cnt++;
      end else begin
        e = pending_rsp.pop_front();
        if (rsp.out_byte !== e.out_byte) begin
          $error("out_byte exp %0h got %0h", e.out_byte, rsp.out_byte); fail_cnt++;
        end
        if (rsp.out_is_data !== e.out_is_data) begin
          $error("out_is_data exp %0b got %0b", e.out_is_data, rsp.out_is_data); fail_cnt++;
        end
        if (rsp.out_valid !== e.out_valid) begin
          $error("out_valid exp %0b got %0b", e.out_valid, rsp.out_valid); fail_cnt++;
        end
        if (rsp.frame_done !== e.frame_done) begin
          $error("frame_done exp %0b got %0b", e.frame_done, rsp.frame_done); fail_cnt++;
        end
        if (rsp.cur_x !== e.cur_x) begin
          $error("cur_x exp %0d got %0d", e.cur_x, rsp.cur_x); fail_cnt++;
        end
        if (rsp.cur_y !== e.cur_y) begin
          $error("cur_y exp %0d got %0d", e.cur_y, rsp.cur_y); fail_cnt++;
        end
      end
    end
  end

  function automatic req_t mk(logic [2:0] kind);
    req_t r;
    r = '0;
    r.req_type = kind;
    return r;
  endfunction

  // header kept small so every glyph read stays inside the loaded font bytes
  function automatic logic [7:0] header_byte(int a);
    case (a)
      0: return 8'($urandom_range(1, 4));
      1: return 8'($urandom_range(0, 8));
      2: return 8'($urandom_range(0, 16));
      default: return 8'($urandom_range(0, 3));
    endcase
  endfunction

  task automatic test_font_load();
    req_t r;
    for (int a = 0; a < FontLoad; a++) begin
      r = mk(REQ_FONT);
      r.font_addr = 12'(a);
      r.font_byte = (a < 4) ? header_byte(a) : 8'($urandom);
      send_req(r);
    end
  endtask

  task automatic test_directed();
    req_t r;
    logic [7:0] codes [6] = '{NlCode, 8'd31, CodeFirstGlyph, CodeLastGlyph, 8'd128, 8'd255};
    r = mk(REQ_LOCATE); r.pos_x = 8'd255; r.pos_y = 8'd255; send_req(r);
    foreach (codes[i]) begin
      r = mk(REQ_PUTC); r.char_code = codes[i]; send_req(r);
    end
    r = mk(REQ_PIXEL); r.pos_x = 8'd0; r.pos_y = 8'd0; r.pixel_on = 1'b1; send_req(r);
    r = mk(REQ_PIXEL); r.pos_x = 8'd127; r.pos_y = 8'd31; r.pixel_on = 1'b1; send_req(r);
    r = mk(REQ_PIXEL); r.pos_x = 8'd255; r.pos_y = 8'd255; r.pixel_on = 1'b1; send_req(r);
    r = mk(REQ_PIXEL); r.pos_x = 8'd0; r.pos_y = 8'd0; r.pixel_on = 1'b0; send_req(r);
    send_req(mk(REQ_REFR));
    send_req(mk(ReqSpare6));
    send_req(mk(ReqSpare7));
    // zero-size glyph header
    r = mk(REQ_FONT); r.font_addr = 12'd1; r.font_byte = 8'd0; send_req(r);
    r = mk(REQ_PUTC); r.char_code = 8'd65; send_req(r);
    r = mk(REQ_FONT); r.font_addr = 12'd1; r.font_byte = 8'd8; send_req(r);
    r = mk(REQ_FONT); r.font_addr = 12'd2; r.font_byte = 8'd16; send_req(r);
    r = mk(REQ_LOCATE); r.pos_x = 8'd30; r.pos_y = 8'd0; send_req(r);
    r = mk(REQ_PUTC); r.char_code = 8'd66; send_req(r);
    send_req(mk(REQ_CLEAR));
    send_req(mk(REQ_REFR));
  endtask

  function automatic req_t random_req();
    req_t r;
    int pick;
    r = req_t'(48'({$urandom, $urandom}));
    pick = $urandom_range(99);
    if (pick < 10) begin
      r.req_type = REQ_FONT;
      if ($urandom_range(9) == 0) begin
        r.font_addr = 12'($urandom_range(0, 3));
        r.font_byte = header_byte(r.font_addr);
      end else if (r.font_addr < 4) r.font_addr = 12'd4;
    end else if (pick < 20) begin
      r.req_type = REQ_LOCATE;
      if ($urandom_range(3) != 0) begin
        r.pos_x = 8'($urandom_range(0, 127));
        r.pos_y = 8'($urandom_range(0, 31));
      end
    end else if (pick < 40) begin
      r.req_type = REQ_PUTC;
      if ($urandom_range(9) == 0) r.char_code = NlCode;
      else if ($urandom_range(9) != 0) r.char_code = 8'($urandom_range(32, 127));
    end else if (pick < 63) begin
      r.req_type = REQ_PIXEL;
      if ($urandom_range(4) != 0) begin
        r.pos_x = 8'($urandom_range(0, 127));
        r.pos_y = 8'($urandom_range(0, 31));
      end
    end else if (pick < 65) r.req_type = REQ_CLEAR;
    else if (pick < 97) r.req_type = REQ_REFR;
    else r.req_type = ($urandom_range(1)) ? ReqSpare6 : ReqSpare7;
    return r;
  endfunction

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      calm = (i >= n / 3) && (i < n / 3 + 40);
      send_req(random_req());
    end
    calm = 0;
  endtask

  task automatic test_full_frame();
    for (int i = 0; i < FrameSlots + 20; i++) send_req(mk(REQ_REFR));
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    foreach (frame_mem[i]) frame_mem[i] = '0;
    foreach (font_mem[i]) font_mem[i] = '0;
    cur_x_q = '0;
    cur_y_q = '0;
    refresh_slot = 0;
    orient_q = '0;
    test_font_load();
    test_directed();
    write_orient(2'd1);
    test_random(200);
    write_orient(2'd3);
    test_full_frame();
    test_random(200);
    write_orient(2'd2);
    test_random(200);
    write_orient(2'd0);
    test_random(200);
    idle_out();
    repeat (20) @(posedge clk);
    if (fail_cnt == 0 && pending_rsp.size() == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
